// File: sv/bhfr_pkg.sv
// Package: shared codes, widths and control bundle for the byte histogram ranker.
`default_nettype none
package bhfr_pkg;

  localparam int SYM_W      = 8;
  localparam int OP_W       = 2;
  localparam int RANK_CNT_W = 32;

  typedef enum logic [OP_W-1:0] {
    OP_COUNT = 2'd0,
    OP_TAKE  = 2'd1,
    OP_CLEAR = 2'd2
  } op_t;

  typedef enum logic {
    ST_IDLE = 1'b0,
    ST_SCAN = 1'b1
  } state_t;

  // Broadcast from the controller to every cell of the row.
  typedef struct packed {
    logic             inc;
    logic             clr;
    logic             zero;
    logic [SYM_W-1:0] symbol;
    logic [SYM_W-1:0] zero_sym;
  } cell_ctrl_t;

endpackage
`default_nettype wire

// File: sv/bhfr_if.sv
// Interfaces: input item channel and ranked result channel.
`default_nettype none
interface bhfr_in_if;
  logic                        valid;
  logic                        ready;
  logic [bhfr_pkg::OP_W-1:0]   op;
  logic [bhfr_pkg::SYM_W-1:0]  symbol;

  modport source (output valid, output op, output symbol, input ready);
  modport sink   (input valid, input op, input symbol, output ready);
endinterface

interface bhfr_out_if;
  logic                             valid;
  logic                             ready;
  logic [bhfr_pkg::SYM_W-1:0]       rank_symbol;
  logic [bhfr_pkg::RANK_CNT_W-1:0]  rank_count;
  logic                             empty_res;

  modport source (output valid, output rank_symbol, output rank_count, output empty_res,
                  input ready);
  modport sink   (input valid, input rank_symbol, input rank_count, input empty_res,
                  output ready);
endinterface
`default_nettype wire

// File: sv/bhfr_cell.sv
// Cell: one symbol counter plus one stage of the running-maximum wave.
`default_nettype none
module bhfr_cell #(
  parameter int COUNT_BITS = 32,
  parameter int CELL_IDX   = 0
) (
  input  wire                             clk,
  input  wire                             rst_n,
  input  bhfr_pkg::cell_ctrl_t            ctrl,
  input  wire [COUNT_BITS-1:0]            prev_cnt,
  input  wire [bhfr_pkg::SYM_W-1:0]       prev_sym,
  output logic [COUNT_BITS-1:0]           best_cnt_r,
  output logic [bhfr_pkg::SYM_W-1:0]      best_sym_r
);

  localparam logic [bhfr_pkg::SYM_W-1:0] MY_SYM = bhfr_pkg::SYM_W'(CELL_IDX);

  logic [COUNT_BITS-1:0]      cnt_r;
  logic [COUNT_BITS-1:0]      cnt_nxt;
  logic [COUNT_BITS-1:0]      best_cnt_nxt;
  logic [bhfr_pkg::SYM_W-1:0] best_sym_nxt;

  always_comb begin
    cnt_nxt = cnt_r;
    priority if (ctrl.clr) begin
      cnt_nxt = '0;
    end else if (ctrl.zero && (ctrl.zero_sym == MY_SYM)) begin
      cnt_nxt = '0;
    end else if (ctrl.inc && (ctrl.symbol == MY_SYM) && (cnt_r != '1)) begin
      cnt_nxt = cnt_r + COUNT_BITS'(1);
    end else begin
      cnt_nxt = cnt_r;
    end
  end

  // Strictly larger wins, so the lower symbol upstream keeps ties.
  always_comb begin
    if (cnt_r > prev_cnt) begin
      best_cnt_nxt = cnt_r;
      best_sym_nxt = MY_SYM;
    end else begin
      best_cnt_nxt = prev_cnt;
      best_sym_nxt = prev_sym;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else begin
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    best_cnt_r <= best_cnt_nxt;
    best_sym_r <= best_sym_nxt;
  end

endmodule
`default_nettype wire

// File: sv/bhfr_ctrl.sv
// Controller: input handshake, scan sequencing and the result register.
`default_nettype none
module bhfr_ctrl #(
  parameter int NUM_SYMBOLS = 256,
  parameter int COUNT_BITS  = 32
) (
  input  wire                         clk,
  input  wire                         rst_n,
  bhfr_in_if.sink                     in_bus,
  bhfr_out_if.source                  out_bus,
  input  wire [COUNT_BITS-1:0]        best_cnt,
  input  wire [bhfr_pkg::SYM_W-1:0]   best_sym,
  output bhfr_pkg::cell_ctrl_t        ctrl
);

  localparam int CNT_W = $clog2(NUM_SYMBOLS + 1);
  localparam logic [CNT_W-1:0] SCAN_LAST = CNT_W'(NUM_SYMBOLS);

  bhfr_pkg::state_t state_r, state_nxt;
  logic [CNT_W-1:0] scan_cnt_r, scan_cnt_nxt;

  logic                            out_valid_r, out_valid_nxt;
  logic [bhfr_pkg::SYM_W-1:0]      out_sym_r, out_sym_nxt;
  logic [bhfr_pkg::RANK_CNT_W-1:0] out_cnt_r, out_cnt_nxt;
  logic                            out_empty_r, out_empty_nxt;

  logic                                   acc;
  logic                                   finish;
  logic                                   found;
  logic [COUNT_BITS+bhfr_pkg::RANK_CNT_W-1:0] cnt_ext;
  bhfr_pkg::op_t                          op;

  assign op      = bhfr_pkg::op_t'(in_bus.op);
  assign acc     = in_bus.valid && in_bus.ready;
  assign found   = (best_cnt != '0);
  assign cnt_ext = {{bhfr_pkg::RANK_CNT_W{1'b0}}, best_cnt};

  assign in_bus.ready        = (state_r == bhfr_pkg::ST_IDLE);
  assign out_bus.valid       = out_valid_r;
  assign out_bus.rank_symbol = out_sym_r;
  assign out_bus.rank_count  = out_cnt_r;
  assign out_bus.empty_res   = out_empty_r;

  always_comb begin
    state_nxt      = state_r;
    scan_cnt_nxt   = scan_cnt_r;
    finish         = 1'b0;
    ctrl.inc       = 1'b0;
    ctrl.clr       = 1'b0;
    ctrl.symbol    = in_bus.symbol;
    unique case (state_r)
      bhfr_pkg::ST_IDLE: begin
        if (acc) begin
          unique case (op)
            bhfr_pkg::OP_COUNT: ctrl.inc = 1'b1;
            bhfr_pkg::OP_CLEAR: ctrl.clr = 1'b1;
            bhfr_pkg::OP_TAKE: begin
              state_nxt    = bhfr_pkg::ST_SCAN;
              scan_cnt_nxt = '0;
            end
            default: ;
          endcase
        end
      end
      bhfr_pkg::ST_SCAN: begin
        // Wait for the wave to cross the row, then for room in the result register.
        if (scan_cnt_r != SCAN_LAST) begin
          scan_cnt_nxt = scan_cnt_r + CNT_W'(1);
        end else if (!out_valid_r || out_bus.ready) begin
          finish    = 1'b1;
          state_nxt = bhfr_pkg::ST_IDLE;
        end
      end
      default: state_nxt = bhfr_pkg::ST_IDLE;
    endcase
    ctrl.zero     = finish && found;
    ctrl.zero_sym = best_sym;
  end

  always_comb begin
    out_valid_nxt = out_valid_r && !out_bus.ready;
    out_sym_nxt   = out_sym_r;
    out_cnt_nxt   = out_cnt_r;
    out_empty_nxt = out_empty_r;
    if (finish) begin
      out_valid_nxt = 1'b1;
      out_empty_nxt = !found;
      out_sym_nxt   = found ? best_sym : '0;
      out_cnt_nxt   = found ? cnt_ext[bhfr_pkg::RANK_CNT_W-1:0] : '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= bhfr_pkg::ST_IDLE;
      scan_cnt_r  <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      scan_cnt_r  <= scan_cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_sym_r   <= out_sym_nxt;
    out_cnt_r   <= out_cnt_nxt;
    out_empty_r <= out_empty_nxt;
  end

endmodule
`default_nettype wire

// File: sv/byte_histogram_frequency_rank_top.sv
// Top level: byte frequency counter with descending-frequency readout.
// Count and clear beats are absorbed one per cycle, back to back, while no take is in progress.
// A take drops in ready while the maximum wave crosses the row one cell per cycle;
// its result is loaded into the output register when the scan ends.
// Results wait in an output register; a take finishes only once that register is free.
// Reset (synchronous, active low) zeroes every counter at once.
`default_nettype none
module byte_histogram_frequency_rank_top #(
  parameter int NUM_SYMBOLS = 256,
  parameter int COUNT_BITS  = 32
) (
  input  wire         clk,
  input  wire         rst_n,
  bhfr_in_if.sink     in_bus,
  bhfr_out_if.source  out_bus
);

  bhfr_pkg::cell_ctrl_t       ctrl;
  logic [COUNT_BITS-1:0]      chain_cnt [NUM_SYMBOLS+1];
  logic [bhfr_pkg::SYM_W-1:0] chain_sym [NUM_SYMBOLS+1];

  assign chain_cnt[0] = '0;
  assign chain_sym[0] = '0;

  for (genvar i = 0; i < NUM_SYMBOLS; i++) begin : g_cell
    bhfr_cell #(
      .COUNT_BITS (COUNT_BITS),
      .CELL_IDX   (i)
    ) u_cell (
      .clk        (clk),
      .rst_n      (rst_n),
      .ctrl       (ctrl),
      .prev_cnt   (chain_cnt[i]),
      .prev_sym   (chain_sym[i]),
      .best_cnt_r (chain_cnt[i+1]),
      .best_sym_r (chain_sym[i+1])
    );
  end

  bhfr_ctrl #(
    .NUM_SYMBOLS (NUM_SYMBOLS),
    .COUNT_BITS  (COUNT_BITS)
  ) u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_bus   (in_bus),
    .out_bus  (out_bus),
    .best_cnt (chain_cnt[NUM_SYMBOLS]),
    .best_sym (chain_sym[NUM_SYMBOLS]),
    .ctrl     (ctrl)
  );

endmodule
`default_nettype wire

// File: sim/bhfr_rank_checker.sv
// Checker: mirrors the byte histogram and compares every ranked result beat.
module bhfr_rank_checker #(
  parameter int NUM_SYMBOLS = 256,
  parameter int COUNT_BITS  = 32
) (
  input  logic clk,
  input  logic rst_n,
  bhfr_in_if   in_mon,
  bhfr_out_if  out_mon,
  output int   fail_cnt,
  output int   pending
);
  import bhfr_pkg::*;

  typedef struct packed {
    logic [SYM_W-1:0]      sym;
    logic [RANK_CNT_W-1:0] cnt;
    logic                  empty;
  } rank_t;

  logic [COUNT_BITS-1:0] tally [NUM_SYMBOLS];
  rank_t                 ranks_due [$];
  int                    errors = 0;
  int                    due = 0;

  assign fail_cnt = errors;
  assign pending  = due;

  task automatic absorb_beat(input logic [OP_W-1:0] op, input logic [SYM_W-1:0] sym);
    rank_t                 top;
    logic [COUNT_BITS-1:0] best;
    int                    best_sym;
    case (op)
      OP_COUNT: begin
        // Drop symbols past the table; hold a full counter.
        if (int'(sym) < NUM_SYMBOLS && tally[sym] != '1) tally[sym] = tally[sym] + 1'b1;
      end
      OP_TAKE: begin
        best = '0;
        best_sym = 0;
        // Strict compare keeps the lowest symbol on ties.
        for (int i = 0; i < NUM_SYMBOLS; i++) begin
          if (tally[i] > best) begin
            best = tally[i];
            best_sym = i;
          end
        end
        if (best == '0) begin
          top = '{sym: '0, cnt: '0, empty: 1'b1};
        end else begin
          tally[best_sym] = '0;
          top = '{sym: SYM_W'(best_sym), cnt: RANK_CNT_W'(best), empty: 1'b0};
        end
        ranks_due.push_back(top);
      end
      OP_CLEAR: begin
        foreach (tally[i]) tally[i] = '0;
      end
      default: ;
    endcase
  endtask

  task automatic check_rank(input rank_t got);
    rank_t want;
    if (ranks_due.size() == 0) begin
      errors++;
      if (errors <= 10)
        $display("rank beat with no take pending: sym %0d count %0d empty %0b",
                 got.sym, got.cnt, got.empty);
    end else begin
      want = ranks_due.pop_front();
      if (got.sym !== want.sym || got.cnt !== want.cnt || got.empty !== want.empty) begin
        errors++;
        if (errors <= 10)
          $display("rank mismatch: expected sym %0d count %0d empty %0b, got sym %0d count %0d empty %0b",
                   want.sym, want.cnt, want.empty, got.sym, got.cnt, got.empty);
      end
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      foreach (tally[i]) tally[i] = '0;
      ranks_due.delete();
    end else begin
      // Retire the output beat first: it can never stem from this edge's input.
      if (out_mon.valid && out_mon.ready)
        check_rank('{sym: out_mon.rank_symbol, cnt: out_mon.rank_count,
                     empty: out_mon.empty_res});
      if (in_mon.valid && in_mon.ready) absorb_beat(in_mon.op, in_mon.symbol);
    end
    due = ranks_due.size();
  end

endmodule

// File: sim/tb_top.sv
// Testbench top: clock, reset, item stimulus, receiver stalls and the final verdict.
module tb_top;
  import bhfr_pkg::*;

  // Narrow counters so saturation is reachable within the run.
  localparam int NUM_SYMBOLS  = 256;
  localparam int COUNT_BITS   = 8;
  localparam int RANDOM_BEATS = 1750;
  localparam int LIMIT_CYCLES = 2_000_000;
  localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;

  typedef enum {RX_OPEN, RX_COIN, RX_BURSTY} rx_mode_t;

  logic     clk = 1'b0;
  logic     rst_n;
  int       fail_cnt;
  int       pending;
  int       burst_left = 0;
  bit       steady = 1'b0;
  int       sent = 0;
  int       cycles = 0;
  rx_mode_t rx_mode = RX_OPEN;
  int       rx_phase_left = 0;
  int       stall_left = 0;

  bhfr_in_if  in_bus ();
  bhfr_out_if out_bus ();

  byte_histogram_frequency_rank_top #(
    .NUM_SYMBOLS(NUM_SYMBOLS),
    .COUNT_BITS (COUNT_BITS)
  ) DUT (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_bus (in_bus),
    .out_bus(out_bus)
  );

  bhfr_rank_checker #(
    .NUM_SYMBOLS(NUM_SYMBOLS),
    .COUNT_BITS (COUNT_BITS)
  ) u_checker (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_mon  (in_bus),
    .out_mon (out_bus),
    .fail_cnt(fail_cnt),
    .pending (pending)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == LIMIT_CYCLES) begin
      $display("Verification failed");
      $finish;
    end
  end

  // Receiver: switch between always ready, coin flips and long stall bursts.
  always @(negedge clk) begin
    if (rx_phase_left == 0) begin
      rx_mode <= rx_mode_t'($urandom_range(0, 2));
      rx_phase_left <= $urandom_range(50, 600);
    end else begin
      rx_phase_left <= rx_phase_left - 1;
    end
    case (rx_mode)
      RX_OPEN: out_bus.ready <= 1'b1;
      RX_COIN: out_bus.ready <= 1'($urandom_range(0, 1));
      default: begin
        if (stall_left != 0) begin
          out_bus.ready <= 1'b0;
          stall_left <= stall_left - 1;
        end else begin
          out_bus.ready <= 1'b1;
          if ($urandom_range(0, 3) == 0) stall_left <= $urandom_range(1, 20);
        end
      end
    endcase
  end

  task automatic issue(input logic [OP_W-1:0] op, input logic [SYM_W-1:0] sym);
    int gap;
    if (burst_left == 0) begin
      gap = (steady || $urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
      repeat (gap) begin
        @(negedge clk);
        in_bus.valid  <= 1'b0;
        in_bus.op     <= OP_W'($urandom);
        in_bus.symbol <= SYM_W'($urandom);
      end
      burst_left = $urandom_range(1, 40);
    end
    burst_left--;
    @(negedge clk);
    in_bus.valid  <= 1'b1;
    in_bus.op     <= op;
    in_bus.symbol <= sym;
    @(posedge clk);
    while (!in_bus.ready) @(posedge clk);
    if (op != OP_UNUSED) sent++;
  endtask

  task automatic drain_results();
    @(negedge clk);
    in_bus.valid <= 1'b0;
    burst_left = 0;
    while (pending != 0) @(negedge clk);
  endtask

  // One histogram: optional clear, skewed counts over a small alphabet, then takes.
  task automatic run_episode(input bit saturate, input bit settle);
    logic [SYM_W-1:0] alph [64];
    int               n_sym;
    int               n_counts;
    int               n_takes;
    int               a;
    int               b;
    int               pick;
    steady = ($urandom_range(0, 3) == 0);
    n_sym = ($urandom_range(0, 7) == 0) ? $urandom_range(13, 64) : $urandom_range(1, 12);
    for (int k = 0; k < n_sym; k++) alph[k] = SYM_W'($urandom);
    if ($urandom_range(0, 5) == 0) alph[0] = '1;
    if ($urandom_range(0, 5) == 0) alph[n_sym-1] = '0;
    if (saturate || $urandom_range(0, 2) == 0) issue(OP_CLEAR, SYM_W'($urandom));
    n_counts = saturate ? $urandom_range(256, 270) : $urandom_range(0, 40);
    repeat (n_counts) begin
      if ($urandom_range(0, 19) == 0) issue(OP_UNUSED, SYM_W'($urandom));
      if ($urandom_range(0, 29) == 0) issue(OP_TAKE, SYM_W'($urandom));
      a = $urandom_range(0, n_sym - 1);
      b = $urandom_range(0, n_sym - 1);
      pick = (a < b) ? a : b;
      if (saturate && $urandom_range(0, 9) != 0) pick = 0;
      issue(OP_COUNT, alph[pick]);
    end
    n_takes = $urandom_range(1, n_sym + 2);
    repeat (n_takes) begin
      if ($urandom_range(0, 5) == 0) issue(OP_COUNT, alph[$urandom_range(0, n_sym - 1)]);
      issue(OP_TAKE, SYM_W'($urandom));
    end
    if (settle) drain_results();
  endtask

  initial begin
    rst_n          = 1'b0;
    in_bus.valid   = 1'b0;
    in_bus.op      = OP_COUNT;
    in_bus.symbol  = '0;
    out_bus.ready  = 1'b0;
    repeat (12) @(negedge clk);
    rst_n <= 1'b1;

    // Take from an empty store, then ties between the symbol extremes.
    issue(OP_TAKE, 8'hFF);
    issue(OP_COUNT, 8'h00);
    issue(OP_COUNT, 8'hFF);
    issue(OP_COUNT, 8'hFF);
    issue(OP_COUNT, 8'hAA);
    issue(OP_COUNT, 8'h55);
    issue(OP_COUNT, 8'h00);
    issue(OP_UNUSED, 8'hFF);
    issue(OP_TAKE, 8'h00);
    issue(OP_TAKE, 8'h00);
    issue(OP_TAKE, 8'h00);
    issue(OP_TAKE, 8'h00);
    issue(OP_TAKE, 8'h00);
    // Clear must wipe pending counts.
    issue(OP_COUNT, 8'h07);
    issue(OP_COUNT, 8'h07);
    issue(OP_CLEAR, 8'h07);
    issue(OP_TAKE, 8'h07);
    // An unused op must not count its symbol.
    issue(OP_COUNT, 8'h80);
    issue(OP_UNUSED, 8'h80);
    issue(OP_UNUSED, 8'h00);
    issue(OP_TAKE, 8'h80);
    issue(OP_TAKE, 8'h80);

    sent = 0;
    run_episode(1'b1, 1'b1);
    while (sent < RANDOM_BEATS) run_episode(1'b0, $urandom_range(0, 4) == 0);

    drain_results();
    repeat (NUM_SYMBOLS + 8) @(negedge clk);
    if (fail_cnt == 0 && pending == 0)
      $display("Verification passed");
    else
      $display("Verification failed");
    $finish;
  end

endmodule
